>>> rtl/core/address_range_pool_index_map_defines.svh
// ----------------------------------------------------------------------------
// address range pool index map: assertion macros
// concurrent checks, left out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_POOL_INDEX_MAP_DEFINES_SVH
`define ADDRESS_RANGE_POOL_INDEX_MAP_DEFINES_SVH

`ifndef SYNTHESIS
`define ARPIM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("arpim assertion failed");
`define ARPIM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arpim implication failed");
`else
`define ARPIM_ASSERT(label, clk, rst, prop)
`define ARPIM_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/arpim_pkg.sv
// ----------------------------------------------------------------------------
// arpim_pkg
// shared widths, register indexes and stage record of the pool index map
// ----------------------------------------------------------------------------
`default_nettype none

package arpim_pkg;

  localparam int ARPIM_MAX_RANGES = 6;
  localparam int ADDR_W           = 32;
  localparam int COUNT_W          = 3;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_0     = 3'd1;

  localparam logic OP_ADDR_TO_INDEX = 1'b0;
  localparam logic OP_INDEX_TO_ADDR = 1'b1;

  typedef logic [ADDR_W-1:0] word_t;

  typedef struct packed {
    logic  op;
    logic  done;
    logic  hit;
    word_t value;
    word_t idx;
    word_t addr;
    word_t sum;
  } stage_t;

endpackage

`default_nettype wire

>>> rtl/core/arpim_query_if.sv
// ----------------------------------------------------------------------------
// arpim_query_if
// query channel: operation and query value with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface arpim_query_if import arpim_pkg::*; ;
  logic  valid;
  logic  ready;
  logic  operation;
  word_t query_value;

  modport source (output valid, output operation, output query_value, input ready);
  modport sink   (input valid, input operation, input query_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/arpim_result_if.sv
// ----------------------------------------------------------------------------
// arpim_result_if
// result channel: membership, pool index, pool address and pool size
// ----------------------------------------------------------------------------
`default_nettype none

interface arpim_result_if import arpim_pkg::*; ;
  logic  valid;
  logic  ready;
  logic  in_set;
  word_t pool_index;
  word_t pool_address;
  word_t pool_size;

  modport source (output valid, output in_set, output pool_index, output pool_address,
                  output pool_size, input ready);
  modport sink   (input valid, input in_set, input pool_index, input pool_address,
                  input pool_size, output ready);
endinterface

`default_nettype wire

>>> rtl/core/address_range_pool_index_map.sv
// ----------------------------------------------------------------------------
// address_range_pool_index_map
// ordered table of inclusive ipv4 ranges seen as one concatenated pool
// ----------------------------------------------------------------------------
// The block takes one query per cycle until the pipeline is full and returns
// one result per query, in order. Each query passes an input register and
// then one pipeline stage per range slot; the result is driven from the last
// range stage. A stall on the result side holds each full stage with no empty
// stage ahead of it, while stages behind an empty stage still move, so a new
// query is refused only once the whole pipeline is full. Each active range
// stage compares the query with its range, updates the index or address and
// adds that range's size to the running pool total. The user must write
// registers through the configuration port only while no query is in flight;
// the block itself does not enforce this.
`default_nettype none

`include "address_range_pool_index_map_defines.svh"

module address_range_pool_index_map import arpim_pkg::*; #(
  parameter int MAX_RANGES = ARPIM_MAX_RANGES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  arpim_query_if.sink                 query,
  arpim_result_if.source              result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [COUNT_W-1:0] range_count;
  word_t              range_lo [MAX_RANGES];
  word_t              range_hi [MAX_RANGES];

  stage_t st    [MAX_RANGES+1];
  logic   v     [MAX_RANGES+1];
  logic   en    [MAX_RANGES+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (cfg_write && cfg_index == REG_RANGE_COUNT) begin
      range_count <= cfg_data[COUNT_W-1:0];
    end
  end

  for (genvar k = 0; k < MAX_RANGES; k++) begin : g_range
    always_ff @(posedge clk) begin
      if (rst) begin
        range_lo[k] <= '0;
        range_hi[k] <= '0;
      end else if (cfg_write && cfg_index == CFG_INDEX_W'(REG_RANGE_0 + k)) begin
        range_lo[k] <= cfg_data[2*ADDR_W-1:ADDR_W];
        range_hi[k] <= cfg_data[ADDR_W-1:0];
      end
    end
  end

  // stall chain, last stage first
  always_comb begin
    en[MAX_RANGES] = !v[MAX_RANGES] || result.ready;
    for (int s = MAX_RANGES - 1; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign query.ready = en[0];

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && query.valid) begin
      st[0].op    <= query.operation;
      st[0].done  <= 1'b0;
      st[0].hit   <= 1'b0;
      st[0].value <= query.query_value;
      st[0].idx   <= '0;
      st[0].addr  <= '0;
      st[0].sum   <= '0;
    end
  end

  // one stage per range slot
  for (genvar s = 1; s <= MAX_RANGES; s++) begin : g_stage
    word_t  lo;
    word_t  hi;
    word_t  span;
    word_t  size;
    logic   active;
    stage_t cur;
    stage_t st_next;

    assign lo     = range_lo[s-1];
    assign hi     = range_hi[s-1];
    assign span   = hi - lo;
    assign size   = span + word_t'(1);
    assign active = range_count > COUNT_W'(s - 1);
    assign cur    = st[s-1];

    always_comb begin
      st_next = cur;
      if (active) begin
        st_next.sum = cur.sum + size;
        if (!cur.done) begin
          if (cur.op == OP_ADDR_TO_INDEX) begin
            if (cur.value >= lo && cur.value <= hi) begin
              st_next.hit  = 1'b1;
              st_next.done = 1'b1;
              st_next.idx  = cur.idx + (cur.value - lo);
            end else begin
              st_next.idx  = cur.idx + size;
            end
          end else begin
            if (span < cur.value) begin
              st_next.value = cur.value - size;
            end else begin
              st_next.addr = lo + cur.value;
              st_next.done = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en[s]) begin
        v[s] <= v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s] && v[s-1]) begin
        st[s] <= st_next;
      end
    end
  end

  assign result.valid        = v[MAX_RANGES];
  assign result.in_set       = st[MAX_RANGES].hit;
  assign result.pool_index   = st[MAX_RANGES].idx;
  assign result.pool_address = st[MAX_RANGES].addr;
  assign result.pool_size    = st[MAX_RANGES].sum;

  // checks
  `ARPIM_ASSERT_IMPL(a_index_op_fields, clk, rst,
    result.valid && st[MAX_RANGES].op == OP_INDEX_TO_ADDR,
    !result.in_set && result.pool_index == '0)
  `ARPIM_ASSERT_IMPL(a_addr_op_fields, clk, rst,
    result.valid && st[MAX_RANGES].op == OP_ADDR_TO_INDEX,
    result.pool_address == '0 && result.in_set == st[MAX_RANGES].done)
  `ARPIM_ASSERT_IMPL(a_empty_table, clk, rst,
    result.valid && range_count == '0,
    !result.in_set && result.pool_index == '0 && result.pool_size == '0)

endmodule

`default_nettype wire
